@@ src/rasum_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the range-add / range-sum store.
package rasum_pkg;

    localparam int unsigned MAX_ELEMENTS_DEF = 1024;
    localparam int unsigned LEN_W            = 11;
    localparam int unsigned DATA_W           = 64;
    localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(1024);

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_ADD_SETUP1,
        CMD_ADD_SETUP2,
        CMD_UPD_WR,
        CMD_QRY_SETUP1,
        CMD_QRY_SETUP2,
        CMD_QRY_ACC,
        CMD_QRY_MUL,
        CMD_QRY_FIN1,
        CMD_QRY_FIN2,
        CMD_PUBLISH
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic is_empty;
        logic upd_done;
        logic qry_done;
    } dp_status_t;

endpackage

@@ src/rasum_ifs.sv @@
`timescale 1ns / 1ps
// Channel interfaces: item requests, sum responses and the length register write.
interface rasum_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [10:0]        range_first;
    logic [10:0]        range_last;
    logic signed [63:0] amount;

    modport source (output valid, op, range_first, range_last, amount, input ready);
    modport sink   (input valid, op, range_first, range_last, amount, output ready);
endinterface

interface rasum_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] range_sum;

    modport source (output valid, range_sum, input ready);
    modport sink   (input valid, range_sum, output ready);
endinterface

interface rasum_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ src/rasum_dp.sv @@
`timescale 1ns / 1ps
// Datapath: two Fenwick-tree memories, index walker, shared multiplier and accumulators.
module rasum_dp #(
    parameter int unsigned MAX_ELEMENTS = rasum_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rasum_pkg::dp_cmd_t          cmd,
    output rasum_pkg::dp_status_t       status,
    input  logic                        cfg_we,
    input  logic [rasum_pkg::LEN_W-1:0] cfg_data,
    input  logic                        item_op,
    input  logic [rasum_pkg::LEN_W-1:0] item_first,
    input  logic [rasum_pkg::LEN_W-1:0] item_last,
    input  logic signed [63:0]          item_amount,
    output logic signed [63:0]          result
);
    import rasum_pkg::*;

    localparam int IW_RAW = $clog2(2 * MAX_ELEMENTS + 2);
    localparam int IW     = (IW_RAW > 12) ? IW_RAW : 12;
    localparam int AW     = $clog2(MAX_ELEMENTS);
    localparam logic [IW-1:0] MAX_I    = IW'(MAX_ELEMENTS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ELEMENTS - 1);

    // b1 holds the per-index add, b2 the add weighted by its position
    logic [63:0] mem1 [MAX_ELEMENTS];
    logic [63:0] mem2 [MAX_ELEMENTS];

    logic [LEN_W-1:0] len_reg;
    logic [AW-1:0]    clr_reg;

    logic          op_reg;
    logic          empty_reg;
    logic [IW-1:0] lo_reg;
    logic [IW-1:0] hi_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] pt_reg;
    logic [63:0]   z_reg;
    logic [63:0]   nz_reg;
    logic [63:0]   d1_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   s1_reg;
    logic [63:0]   s2_reg;
    logic [63:0]   total_reg;
    logic [63:0]   result_reg;
    logic [63:0]   rd1_reg;
    logic [63:0]   rd2_reg;

    logic [IW-1:0] len_eff;
    logic [IW-1:0] lo_in;
    logic [IW-1:0] hi_in;
    logic [IW-1:0] lowbit;
    logic [AW-1:0] mem_addr;
    logic [AW-1:0] waddr;
    logic          we;
    logic [63:0]   wd1;
    logic [63:0]   wd2;
    logic [63:0]   mul_a;
    logic [IW-1:0] mul_b;
    logic [63:0]   mul_p;

    always_comb
    begin
        len_eff = (IW'(len_reg) > MAX_I) ? MAX_I : IW'(len_reg);
        lo_in   = (item_first == '0) ? IW'(1) : IW'(item_first);
        hi_in   = (IW'(item_last) > len_eff) ? len_eff : IW'(item_last);
    end

    assign lowbit   = idx_reg & (~idx_reg + IW'(1));
    assign mem_addr = AW'(idx_reg - IW'(1));

    always_comb
    begin
        case (cmd.code)
            CMD_ADD_SETUP1:
            begin
                mul_a = z_reg;
                mul_b = lo_reg - IW'(1);
            end
            CMD_ADD_SETUP2:
            begin
                mul_a = nz_reg;
                mul_b = hi_reg;
            end
            default:
            begin
                mul_a = s1_reg;
                mul_b = pt_reg;
            end
        endcase
    end

    assign mul_p = 64'(mul_a * 64'(mul_b));

    assign we    = (cmd.code == CMD_CLEAR) || (cmd.code == CMD_UPD_WR);
    assign waddr = (cmd.code == CMD_CLEAR) ? clr_reg : mem_addr;
    assign wd1   = (cmd.code == CMD_CLEAR) ? 64'd0 : rd1_reg + d1_reg;
    assign wd2   = (cmd.code == CMD_CLEAR) ? 64'd0 : rd2_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem1[waddr] <= wd1;
            mem2[waddr] <= wd2;
        end
        rd1_reg <= mem1[mem_addr];
        rd2_reg <= mem2[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
            clr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_data;
            if (cmd.code == CMD_CLEAR)
                clr_reg <= clr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.code)
            CMD_LOAD:
            begin
                op_reg    <= item_op;
                lo_reg    <= lo_in;
                hi_reg    <= hi_in;
                empty_reg <= lo_in > hi_in;
                z_reg     <= item_amount;
                nz_reg    <= 64'd0 - item_amount;
                total_reg <= 64'd0;
            end
            CMD_ADD_SETUP1:
            begin
                d1_reg   <= z_reg;
                prod_reg <= mul_p;
                idx_reg  <= lo_reg;
            end
            CMD_ADD_SETUP2:
            begin
                d1_reg   <= nz_reg;
                prod_reg <= mul_p;
                idx_reg  <= hi_reg + IW'(1);
            end
            CMD_UPD_WR:
                idx_reg <= idx_reg + lowbit;
            CMD_QRY_SETUP1:
            begin
                idx_reg <= hi_reg;
                pt_reg  <= hi_reg;
                s1_reg  <= 64'd0;
                s2_reg  <= 64'd0;
            end
            CMD_QRY_SETUP2:
            begin
                idx_reg <= lo_reg - IW'(1);
                pt_reg  <= lo_reg - IW'(1);
                s1_reg  <= 64'd0;
                s2_reg  <= 64'd0;
            end
            CMD_QRY_ACC:
            begin
                s1_reg  <= s1_reg + rd1_reg;
                s2_reg  <= s2_reg + rd2_reg;
                idx_reg <= idx_reg - lowbit;
            end
            CMD_QRY_MUL:
                prod_reg <= mul_p;
            // prefix(i) = i * sum(b1) - sum(b2)
            CMD_QRY_FIN1:
                total_reg <= prod_reg - s2_reg;
            CMD_QRY_FIN2:
                total_reg <= total_reg - prod_reg + s2_reg;
            CMD_PUBLISH:
                result_reg <= total_reg;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.clr_last = (clr_reg == CLR_LAST);
        status.is_query = op_reg;
        status.is_empty = empty_reg;
        status.upd_done = (idx_reg > MAX_I);
        status.qry_done = (idx_reg == '0);
    end

    assign result = result_reg;

    a_upd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_UPD_WR) |-> (idx_reg != '0 && idx_reg <= MAX_I))
        else $error("update step outside the tree");

    a_acc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_QRY_ACC) |-> (idx_reg != '0))
        else $error("prefix step at index zero");

endmodule

@@ src/rasum_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences clearing, update passes and prefix-sum passes.
module rasum_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rasum_pkg::dp_cmd_t    cmd,
    input  rasum_pkg::dp_status_t status
);
    import rasum_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_ADD1     = 4'd3;
    localparam logic [3:0] S_UPD_RD   = 4'd4;
    localparam logic [3:0] S_UPD_WR   = 4'd5;
    localparam logic [3:0] S_ADD2     = 4'd6;
    localparam logic [3:0] S_QRY1     = 4'd7;
    localparam logic [3:0] S_QRY_RD   = 4'd8;
    localparam logic [3:0] S_QRY_ACC  = 4'd9;
    localparam logic [3:0] S_QMUL     = 4'd10;
    localparam logic [3:0] S_QFIN     = 4'd11;
    localparam logic [3:0] S_QRY2     = 4'd12;
    localparam logic [3:0] S_PUBLISH  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       pass_reg;
    logic       pass_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.code       = CMD_NONE;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.code = CMD_CLEAR;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_empty)
                    state_next = status.is_query ? S_PUBLISH : S_IDLE;
                else
                    state_next = status.is_query ? S_QRY1 : S_ADD1;
            end
            S_ADD1:
            begin
                cmd.code   = CMD_ADD_SETUP1;
                pass_next  = 1'b0;
                state_next = S_UPD_RD;
            end
            S_UPD_RD:
            begin
                if (status.upd_done)
                    state_next = pass_reg ? S_IDLE : S_ADD2;
                else
                    state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                cmd.code   = CMD_UPD_WR;
                state_next = S_UPD_RD;
            end
            S_ADD2:
            begin
                cmd.code   = CMD_ADD_SETUP2;
                pass_next  = 1'b1;
                state_next = S_UPD_RD;
            end
            S_QRY1:
            begin
                cmd.code   = CMD_QRY_SETUP1;
                pass_next  = 1'b0;
                state_next = S_QRY_RD;
            end
            S_QRY_RD:
            begin
                state_next = status.qry_done ? S_QMUL : S_QRY_ACC;
            end
            S_QRY_ACC:
            begin
                cmd.code   = CMD_QRY_ACC;
                state_next = S_QRY_RD;
            end
            S_QMUL:
            begin
                cmd.code   = CMD_QRY_MUL;
                state_next = S_QFIN;
            end
            S_QFIN:
            begin
                cmd.code   = pass_reg ? CMD_QRY_FIN2 : CMD_QRY_FIN1;
                state_next = pass_reg ? S_PUBLISH : S_QRY2;
            end
            S_QRY2:
            begin
                cmd.code   = CMD_QRY_SETUP2;
                pass_next  = 1'b1;
                state_next = S_QRY_RD;
            end
            S_PUBLISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.code       = CMD_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("item taken during clearing pass");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_PUBLISH) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transaction");

    a_valid_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_PUBLISH))
        else $error("result raised outside publish");

endmodule

@@ src/range_add_range_sum_tree_unit.sv @@
`timescale 1ns / 1ps
// Range-add / range-sum store over signed 64-bit elements, 1-based, sums wrapping mod 2^64.
// The elements are kept as two Fenwick trees (point adds and position-weighted adds) in
// memories with a read port and a write port; a range add is two update walks and a range
// sum two prefix walks. Every tree step is a memory read state followed by a write or
// accumulate state. An empty range skips the walks, and an empty query publishes zero.
// One item is worked on at a time; a finished sum waits in an output register while the
// next item is taken, and a query whose sum finds that register still full waits until
// the receiver takes it. After reset the memories are cleared one entry per cycle, and no
// item is accepted before the last entry is cleared; length writes are taken at any time
// and should be made only while the block is idle.
module range_add_range_sum_tree_unit #(
    parameter int unsigned MAX_ELEMENTS = rasum_pkg::MAX_ELEMENTS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    rasum_in_if.sink     req,
    rasum_out_if.source  rsp,
    rasum_cfg_if.sink    cfg
);
    import rasum_pkg::*;

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic        in_ready;
    logic        out_valid;
    logic signed [63:0] result;

    rasum_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    rasum_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.data),
        .item_op     (req.op),
        .item_first  (req.range_first),
        .item_last   (req.range_last),
        .item_amount (req.amount),
        .result      (result)
    );

    assign req.ready     = in_ready;
    assign rsp.valid     = out_valid;
    assign rsp.range_sum = result;
    assign cfg.ready     = 1'b1;

endmodule

@@ bench/range_add_range_sum_tree_unit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the range-add / range-sum store: predicts sums from watched transactions.
module range_add_range_sum_tree_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    rasum_in_if.sink    req_mon,
    rasum_out_if.sink   rsp_mon,
    rasum_cfg_if.sink   cfg_mon,
    output int unsigned fail_count,
    output int unsigned sums_pending,
    output int unsigned sums_seen
);
    localparam int unsigned ELEMS = rasum_pkg::MAX_ELEMENTS_DEF;

    // element values kept directly; the tree shape does not change the sums
    logic [63:0] element_val [1:ELEMS];
    logic [10:0] len_reg;
    logic [63:0] sum_queue [$];
    logic [63:0] want_sum;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic void apply_item(input logic op, input logic [10:0] first_idx,
                                       input logic [10:0] last_idx, input logic [63:0] amt);
        int unsigned lim, lo, hi;
        logic [63:0] acc;
        lim = (len_reg > ELEMS) ? ELEMS : len_reg;
        lo  = (first_idx == 0) ? 1 : first_idx;
        hi  = (last_idx > lim) ? lim : last_idx;
        acc = '0;
        for (int unsigned i = lo; i <= hi; i++)
        begin
            if (op == 1'b0)
                element_val[i] += amt;
            else
                acc += element_val[i];
        end
        if (op == 1'b1)
            sum_queue.push_back(acc);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= ELEMS; i++)
                element_val[i] = '0;
            len_reg = rasum_pkg::LEN_RESET;
            sum_queue.delete();
            fail_count = 0;
            sums_seen = 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
                len_reg = cfg_mon.data;
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                sums_seen++;
                if (sum_queue.size() == 0)
                    report_mismatch("unexpected range_sum", rsp_mon.range_sum, '0);
                else
                begin
                    want_sum = sum_queue.pop_front();
                    if (rsp_mon.range_sum !== want_sum)
                        report_mismatch("range_sum", rsp_mon.range_sum, want_sum);
                end
            end
            if (req_mon.valid && req_mon.ready)
                apply_item(req_mon.op, req_mon.range_first, req_mon.range_last,
                           req_mon.amount);
        end
        sums_pending = sum_queue.size();
    end

    final
    begin
    end
endmodule

@@ bench/range_add_range_sum_tree_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top: stimulus, ready pattern, length phases and the verdict.
module range_add_range_sum_tree_unit_tb;
    import rasum_pkg::*;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int unsigned fail_count, sums_pending, sums_seen, cycle_count, items_sent;
    bit long_stall = 1'b0;
    bit long_stall_go = 1'b0;
    int unsigned stall_left = 0;

    rasum_in_if  req ();
    rasum_out_if rsp ();
    rasum_cfg_if cfg ();

    range_add_range_sum_tree_unit dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    range_add_range_sum_tree_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req_mon(req.sink), .rsp_mon(rsp.sink),
        .cfg_mon(cfg.sink), .fail_count(fail_count), .sums_pending(sums_pending),
        .sums_seen(sums_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        req.valid = 1'b0; req.op = OP_ADD; req.range_first = '0;
        req.range_last = '0; req.amount = '0;
        cfg.valid = 1'b0; cfg.data = '0;
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("range_add_range_sum_tree_unit_tb: done, errors");
            $finish;
        end
    end

    // long receiver hold-off, timed here while the sender keeps offering items
    initial
    begin
        wait (long_stall_go);
        long_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_stall <= 1'b0;
    end

    // receiver: random stall pattern, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (long_stall)
            rsp.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 12);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(0, 3) != 0) || (cycle_count[9:8] == 2'b11);
    end

    task automatic send_item(input logic op, input logic [10:0] first_idx,
                             input logic [10:0] last_idx, input logic [63:0] amt);
        req.valid <= 1'b1;
        req.op <= op;
        req.range_first <= first_idx;
        req.range_last <= last_idx;
        req.amount <= amt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic idle_sender(input int unsigned n);
        req.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sums_pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_length(input logic [10:0] len);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= len;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand_amount();
        case ($urandom_range(0, 4))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return {$urandom, $urandom};
            default: return 64'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    task automatic random_phase(input int unsigned n, input int unsigned span);
        logic [10:0] a, b;
        int unsigned burst;
        burst = 0;
        for (int unsigned k = 0; k < n; k++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) == 0)
                    idle_sender($urandom_range(1, 60));
            end
            burst--;
            if ($urandom_range(0, 9) == 0)
            begin
                a = 11'($urandom);
                b = 11'($urandom);
            end
            else
            begin
                a = 11'($urandom_range(0, span));
                b = 11'($urandom_range(0, span + 1));
            end
            send_item($urandom_range(0, 1) ? OP_QUERY : OP_ADD, a, b, rand_amount());
        end
    endtask

    initial
    begin
        cycle_count = 0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both operations, clipping, empty ranges, wrap
        send_item(OP_QUERY, 11'd1, 11'd1024, '0);
        send_item(OP_ADD, 11'd0, 11'd1024, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_QUERY, 11'd1, 11'd1024, '0);
        send_item(OP_ADD, 11'd1024, 11'd1024, 64'h8000_0000_0000_0000);
        send_item(OP_QUERY, 11'd1024, 11'd2047, '0);
        send_item(OP_ADD, 11'd2047, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_QUERY, 11'd5, 11'd4, '0);
        send_item(OP_ADD, 11'd7, 11'd3, 64'd99);
        send_item(OP_QUERY, 11'd0, 11'd0, '0);
        send_item(OP_ADD, 11'd512, 11'd513, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_QUERY, 11'd511, 11'd514, '0);
        send_item(OP_QUERY, 11'd1, 11'd2047, '0);
        write_length(11'd0);
        send_item(OP_ADD, 11'd1, 11'd10, 64'd5);
        send_item(OP_QUERY, 11'd1, 11'd10, '0);
        write_length(11'd2047);
        send_item(OP_QUERY, 11'd1, 11'd2047, '0);
        write_length(11'd1);
        send_item(OP_ADD, 11'd1, 11'd2, 64'd3);
        send_item(OP_QUERY, 11'd0, 11'd1024, '0);
        write_length(11'd16);
        send_item(OP_QUERY, 11'd1, 11'd1024, '0);

        random_phase(300, 20);

        // long hold-off on the receiver while items keep coming
        long_stall_go = 1'b1;
        for (int unsigned k = 0; k < 8; k++)
            send_item(OP_QUERY, 11'($urandom_range(1, 16)), 11'd16, '0);
        drain();

        write_length(11'd1024);
        random_phase(350, 1030);
        write_length(11'd300);
        random_phase(250, 310);
        write_length(11'd1024);
        random_phase(330, 1100);

        drain();
        $display("covered %0d items and %0d sums over lengths 0, 1, 16, 300, 1024, 2047",
                 items_sent, sums_seen);
        if (fail_count == 0)
            $display("range_add_range_sum_tree_unit_tb: done, clean");
        else
            $display("range_add_range_sum_tree_unit_tb: done, errors");
        $finish;
    end
endmodule
